@@ rtl/table_newton_interpolator_defines.svh @@
// ----------------------------------------------------------------------------
// table_newton_interpolator_defines
// Assertion macros shared by the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef TABLE_NEWTON_INTERPOLATOR_DEFINES_SVH
`define TABLE_NEWTON_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH
// check under reset qualification
`define TNI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define TNI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TNI_ASSERT(label, prop, msg)
`define TNI_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/tni_pkg.sv @@
// ----------------------------------------------------------------------------
// tni_pkg
// Shared constants, codes and saturation helpers of the interpolator.
// ----------------------------------------------------------------------------
package tni_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int FRAC_BITS      = 16;
  localparam int VAL_W          = 32;
  localparam int DD_W           = 64;
  localparam int IDX_W          = 8;
  localparam int ORDER_W        = 2;
  localparam int PIU_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 9;
  localparam int STATUS_W       = 2;

  // divider: dividend is |num| << FRAC_BITS, two quotient bits per cycle
  localparam int DVD_W     = DD_W + FRAC_BITS;
  localparam int DIV_STEPS = DVD_W / 2;

  localparam logic signed [DD_W-1:0] DD_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [0:0] CMD_LOAD  = 1'b0;
  localparam logic [0:0] CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 1'd1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;

  function automatic logic signed [DD_W-1:0] clamp_dd(input logic signed [DD_W-1:0] v);
    logic signed [DD_W-1:0] r;
    r = v;
    if (v > DD_LIM) r = DD_LIM;
    else if (v < -DD_LIM) r = -DD_LIM;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [DD_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    r = v[VAL_W-1:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    return r;
  endfunction

endpackage

@@ rtl/tni_ram.sv @@
// ----------------------------------------------------------------------------
// tni_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tni_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/tni_div.sv @@
// ----------------------------------------------------------------------------
// tni_div
// Serial fixed-point divider: trunc(num * 2^FRAC_BITS / den), saturated.
// ----------------------------------------------------------------------------
module tni_div
  import tni_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DD_W-1:0] num,
  input  logic signed [VAL_W:0]  den,
  output logic                   busy,
  output logic                   done,
  output logic signed [DD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy_r, done_r, neg_r, zero_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r, quo_r;
  logic [VAL_W:0]   rem_r, ud_r;
  logic [VAL_W+1:0] r1, r2;
  logic [VAL_W:0]   r1_s, r2_s;
  logic             q1, q2;
  logic [DD_W-1:0]  un, mag;
  logic [VAL_W:0]   ud;

  assign un = num[DD_W-1] ? DD_W'(-num) : DD_W'(num);
  assign ud = den[VAL_W] ? (VAL_W+1)'(-den) : (VAL_W+1)'(den);

  // two restoring steps per cycle
  always_comb begin
    r1 = {rem_r, dvd_r[DVD_W-1]};
    q1 = (r1 >= {1'b0, ud_r});
    r1_s = q1 ? (VAL_W+1)'(r1 - {1'b0, ud_r}) : r1[VAL_W:0];
    r2 = {r1_s, dvd_r[DVD_W-2]};
    q2 = (r2 >= {1'b0, ud_r});
    r2_s = q2 ? (VAL_W+1)'(r2 - {1'b0, ud_r}) : r2[VAL_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS);
        dvd_r  <= {un, {FRAC_BITS{1'b0}}};
        quo_r  <= '0;
        rem_r  <= '0;
        ud_r   <= ud;
        neg_r  <= num[DD_W-1] ^ den[VAL_W];
        zero_r <= (den == '0);
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DVD_W-3:0], 2'b00};
        rem_r <= r2_s;
        quo_r <= {quo_r[DVD_W-3:0], q1, q2};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_r) mag = '0;
    else if (|quo_r[DVD_W-1:DD_W-2]) mag = DD_W'(DD_LIM);
    else mag = {2'b00, quo_r[DD_W-3:0]};
    quot = neg_r ? -$signed(mag) : $signed(mag);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

@@ rtl/tni_mul.sv @@
// ----------------------------------------------------------------------------
// tni_mul
// Fixed-point multiplier: trunc(|a*b| / 2^FRAC_BITS) with sign, saturated.
// Two 32x33 partial products: the low one is registered, then added to the high one.
// ----------------------------------------------------------------------------
module tni_mul
  import tni_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DD_W-1:0] a,
  input  logic signed [VAL_W:0]  b,
  output logic                   done,
  output logic signed [DD_W-1:0] prod
);

  localparam int PP_W  = 2 * VAL_W + 1;
  localparam int SUM_W = PP_W + VAL_W;

  logic [1:0]             phase_r;
  logic                   done_r, neg_r;
  logic [DD_W-1:0]        ua_r;
  logic [VAL_W:0]         ub_r;
  logic [PP_W-1:0]        plo_r;
  logic [SUM_W-1:0]       sum_r;
  logic [PP_W-1:0]        phi;
  logic [SUM_W-FRAC_BITS-1:0] m_full;
  logic [DD_W-1:0]        mag;

  assign phi = PP_W'(ua_r[DD_W-1:VAL_W]) * PP_W'(ub_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        phase_r <= 2'd1;
        ua_r    <= a[DD_W-1] ? DD_W'(-a) : DD_W'(a);
        ub_r    <= b[VAL_W] ? (VAL_W+1)'(-b) : (VAL_W+1)'(b);
        neg_r   <= a[DD_W-1] ^ b[VAL_W];
      end else if (phase_r == 2'd1) begin
        plo_r   <= PP_W'(ua_r[VAL_W-1:0]) * PP_W'(ub_r);
        phase_r <= 2'd2;
      end else if (phase_r == 2'd2) begin
        sum_r   <= SUM_W'(plo_r) + {phi, {VAL_W{1'b0}}};
        phase_r <= 2'd0;
        done_r  <= 1'b1;
      end
    end
  end

  always_comb begin
    m_full = sum_r[SUM_W-1:FRAC_BITS];
    if (m_full > (SUM_W-FRAC_BITS)'(DD_LIM)) mag = DD_W'(DD_LIM);
    else mag = m_full[DD_W-1:0];
    prod = neg_r ? -$signed(mag) : $signed(mag);
  end

  assign done = done_r;

endmodule

@@ rtl/table_newton_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_newton_interpolator
// Table of sample points with binary search and Newton interpolation up to
// cubic order.
//
// Input channel (in_valid / in_stall): a load item writes one table point, a
// query item interpolates at in_query_x. Every item gives one result on the
// output channel (out_valid / out_stall). Configuration writes (cfg_we) set
// the order and the number of points searched; the user must make them only
// while the block is idle, which the block itself does not enforce. One item
// is worked on at a time; in_stall is high until its result sits in the
// output register. A query runs a binary search, reads order+1 points, forms
// order*(order+1)/2 divided differences and then order multiply-adds. The
// divider, two quotient bits per cycle over an 80-bit dividend, takes most
// of a query; the single RAM read port sets the search and point fetch.
// The output register holds a result while out_stall is high; the next
// item may already be accepted then, and its result waits behind it.
// Reset (rst_n low, synchronous) drops any item in progress, empties the
// output and sets order 1 and two points in use. Table contents survive.
// ----------------------------------------------------------------------------
`include "table_newton_interpolator_defines.svh"

module table_newton_interpolator
  import tni_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [IDX_W-1:0]           in_point_index,
  input  logic signed [VAL_W-1:0]    in_point_x,
  input  logic signed [VAL_W-1:0]    in_point_value,
  input  logic signed [VAL_W-1:0]    in_query_x,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VAL_W-1:0]    out_result_value,
  output logic [STATUS_W-1:0]        out_status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = ((NW > PIU_W) ? NW : PIU_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_RD0, ST_RDN, ST_LOOP, ST_MID, ST_WIN, ST_PTS,
    ST_DDS, ST_DDW, ST_HMS, ST_HMW, ST_FIN, ST_RES
  } state_t;

  state_t                  state_r;
  logic [ORDER_W-1:0]      order_r;
  logic [PIU_W-1:0]        points_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_val_r, res_val_r, q_r;
  logic [STATUS_W-1:0]     out_st_r, res_st_r;
  logic [ORDER_W-1:0]      k_r, j_r, lvl_r, i_r;
  logic [CW-1:0]           n_r;
  logic [AW-1:0]           left_r, right_r, start_r;
  logic signed [VAL_W-1:0] xl_r, yl_r, xr_r, yr_r;
  logic signed [VAL_W-1:0] xs_r [4];
  logic signed [DD_W-1:0]  c_r [4];
  logic signed [DD_W-1:0]  acc_r;

  logic                    in_xfer, ram_we, slot_ok;
  logic [AW-1:0]           ram_addr, mid_w, start_w;
  logic [CW-1:0]           piu_w, n_w;
  logic signed [VAL_W-1:0] rd_x, rd_y;
  logic                    div_start, div_busy, div_done, mul_start, mul_done;
  logic signed [DD_W-1:0]  div_num, div_quot, mul_prod, hsum;
  logic signed [VAL_W:0]   div_den, mul_b;
  logic                    fit_r, fit_l, adjacent, narrow;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign slot_ok  = (CW'(in_point_index) < CW'(MAX_POINTS));
  assign ram_we   = in_xfer && (in_command == CMD_LOAD) && slot_ok;

  assign piu_w = CW'(points_r);
  assign n_w   = (piu_w > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : piu_w;

  assign mid_w    = left_r + ((right_r - left_r) >> 1);
  assign narrow   = (CW'(right_r) <= CW'(left_r) + CW'(1));
  assign adjacent = (CW'(right_r) == CW'(left_r) + CW'(1));
  assign fit_r    = (CW'(left_r) + CW'(k_r) < n_r);
  assign fit_l    = (CW'(left_r) + CW'(1) >= CW'(k_r));
  assign start_w  = fit_r ? left_r : AW'(CW'(left_r) + CW'(1) - CW'(k_r));

  always_comb begin
    unique case (state_r)
      ST_IDLE: ram_addr = AW'(in_point_index);
      ST_RD0:  ram_addr = AW'(n_r - CW'(1));
      ST_LOOP: ram_addr = mid_w;
      ST_WIN:  ram_addr = start_w;
      ST_PTS:  ram_addr = start_r + AW'(j_r) + AW'(1);
      default: ram_addr = '0;
    endcase
  end

  tni_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_point_x), .rdata(rd_x)
  );

  tni_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_point_value), .rdata(rd_y)
  );

  assign div_start = (state_r == ST_DDS);
  assign div_num   = c_r[j_r] - c_r[j_r - ORDER_W'(1)];
  assign div_den   = (VAL_W+1)'(xs_r[j_r]) - (VAL_W+1)'(xs_r[j_r - lvl_r]);

  tni_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  assign mul_start = (state_r == ST_HMS);
  assign mul_b     = (VAL_W+1)'(q_r) - (VAL_W+1)'(xs_r[i_r]);
  assign hsum      = c_r[i_r] + mul_prod;

  tni_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(acc_r), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      order_r     <= ORDER_W'(1);
      points_r    <= PIU_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORDER:  order_r  <= cfg_wdata[ORDER_W-1:0];
          REG_POINTS: points_r <= cfg_wdata[PIU_W-1:0];
          default:    ;
        endcase
      end
      // drop the output transfer; a hand-over in ST_RES sets it instead
      if (out_valid_r && !out_stall && state_r != ST_RES) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            q_r       <= in_query_x;
            k_r       <= order_r;
            n_r       <= n_w;
            res_val_r <= '0;
            res_st_r  <= STAT_OK;
            state_r   <= (in_command == CMD_LOAD) ? ST_RES : ST_CHK;
          end
        end
        ST_CHK: begin
          if (n_r == '0 || (n_r - CW'(1)) < CW'(k_r)) begin
            res_st_r <= STAT_ORDER;
            state_r  <= ST_RES;
          end else begin
            state_r <= ST_RD0;
          end
        end
        ST_RD0: begin
          xl_r    <= rd_x;
          yl_r    <= rd_y;
          left_r  <= '0;
          right_r <= AW'(n_r - CW'(1));
          state_r <= ST_RDN;
        end
        ST_RDN: begin
          xr_r <= rd_x;
          yr_r <= rd_y;
          if (q_r < xl_r || q_r > rd_x) begin
            res_st_r <= STAT_RANGE;
            state_r  <= ST_RES;
          end else begin
            state_r <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          priority if (xl_r == q_r) begin
            res_val_r <= yl_r;
            state_r   <= ST_RES;
          end else if (xr_r == q_r) begin
            res_val_r <= yr_r;
            state_r   <= ST_RES;
          end else if (narrow) begin
            state_r <= ST_WIN;
          end else begin
            state_r <= ST_MID;
          end
        end
        ST_MID: begin
          if (rd_x <= q_r) begin
            left_r <= mid_w;
            xl_r   <= rd_x;
            yl_r   <= rd_y;
          end else begin
            right_r <= mid_w;
            xr_r    <= rd_x;
            yr_r    <= rd_y;
          end
          state_r <= ST_LOOP;
        end
        ST_WIN: begin
          if (!adjacent || !(fit_r || fit_l)) begin
            res_st_r <= STAT_ORDER;
            state_r  <= ST_RES;
          end else begin
            start_r <= start_w;
            j_r     <= '0;
            state_r <= ST_PTS;
          end
        end
        ST_PTS: begin
          xs_r[j_r] <= rd_x;
          c_r[j_r]  <= DD_W'(rd_y);
          if (j_r == k_r) begin
            if (k_r == '0) begin
              acc_r   <= DD_W'(rd_y);
              state_r <= ST_FIN;
            end else begin
              lvl_r   <= ORDER_W'(1);
              j_r     <= k_r;
              state_r <= ST_DDS;
            end
          end else begin
            j_r <= j_r + ORDER_W'(1);
          end
        end
        ST_DDS: begin
          state_r <= ST_DDW;
        end
        ST_DDW: begin
          if (div_done) begin
            c_r[j_r] <= div_quot;
            if (j_r == lvl_r) begin
              if (lvl_r == k_r) begin
                acc_r   <= div_quot;
                i_r     <= k_r - ORDER_W'(1);
                state_r <= ST_HMS;
              end else begin
                lvl_r   <= lvl_r + ORDER_W'(1);
                j_r     <= k_r;
                state_r <= ST_DDS;
              end
            end else begin
              j_r     <= j_r - ORDER_W'(1);
              state_r <= ST_DDS;
            end
          end
        end
        ST_HMS: begin
          state_r <= ST_HMW;
        end
        ST_HMW: begin
          if (mul_done) begin
            acc_r <= clamp_dd(hsum);
            if (i_r == '0) begin
              state_r <= ST_FIN;
            end else begin
              i_r     <= i_r - ORDER_W'(1);
              state_r <= ST_HMS;
            end
          end
        end
        ST_FIN: begin
          res_val_r <= sat32(acc_r);
          res_st_r  <= STAT_OK;
          state_r   <= ST_RES;
        end
        ST_RES: begin
          // hand over once the output register is free or being drained
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_st_r    <= res_st_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;

  `TNI_ASSERT(a_accept_idle, in_xfer |-> (state_r == ST_IDLE), "item taken while busy")
  `TNI_ASSERT(a_err_zero, (out_valid_r && out_st_r != STAT_OK) |-> (out_val_r == '0), "error result not zero")
  `TNI_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
  `TNI_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (!out_valid_r && state_r == ST_IDLE), "reset left state")

endmodule

@@ tb/sv/table_newton_interpolator_test.sv @@
// ----------------------------------------------------------------------------
// table_newton_interpolator_test
// Self-checking bench for the point table interpolator. Directed rows cover
// exact hits, range and order errors, the window edge and equal abscissae.
// Random phases reload sorted tables and fire queries under sender gaps and
// receiver stalls. Untyped queries are checked by a local Newton predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module table_newton_interpolator_test;
  import tni_pkg::*;

  localparam longint LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam int Q1 = 65536;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STATUS_W-1:0]     status;
  } interp_result_t;

  typedef enum {ROW_LOAD, ROW_QUERY, ROW_ORDER, ROW_POINTS} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    int                      slot;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    bit                      typed;
    logic signed [VAL_W-1:0] exp_value;
    logic [STATUS_W-1:0]     exp_status;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_command;
  logic [IDX_W-1:0] in_point_index;
  logic signed [VAL_W-1:0] in_point_x, in_point_value, in_query_x;
  logic out_valid, out_stall;
  logic signed [VAL_W-1:0] out_result_value;
  logic [STATUS_W-1:0] out_status;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  table_newton_interpolator uut (.*);

  // predictor state
  logic signed [VAL_W-1:0] tab_x [256];
  logic signed [VAL_W-1:0] tab_y [256];
  logic [ORDER_W-1:0] cur_order;
  logic [PIU_W-1:0]   cur_points;

  interp_result_t pending_results[$];
  int errors, n_results, gap_pct, stall_pct, hold_left;
  int status_seen [3];
  bit hold_req;
  longint cycles;

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[table_newton_interpolator] ERROR");
      $finish;
    end
  end

  function automatic longint sat_dd(longint v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic longint quotient_q(longint num, longint den);
    logic [63:0] un, ud, qi, r, m;
    bit neg;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    if (ud == 0) return 0;
    qi = un / ud;
    r = un % ud;
    if (qi > (LIM >> FRAC_BITS)) m = LIM;
    else m = (qi << FRAC_BITS) + ((r << FRAC_BITS) / ud);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint product_q(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ua, ub, m;
    bit neg;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    p = {64'd0, ua} * {64'd0, ub};
    m = p[FRAC_BITS +: 64];
    if (p[127:64+FRAC_BITS] != 0 || m > LIM) m = LIM;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic interp_result_t newton_at(logic signed [VAL_W-1:0] q);
    interp_result_t res;
    int n, k, left, right, mid, start;
    longint xs [4];
    longint c [4];
    longint acc;
    res.value = 0;
    res.status = STAT_ORDER;
    n = (cur_points > 256) ? 256 : cur_points;
    k = cur_order;
    if (n == 0 || n - 1 < k) return res;
    left = 0;
    right = n - 1;
    if (q < tab_x[0] || q > tab_x[right]) begin
      res.status = STAT_RANGE;
      return res;
    end
    res.status = STAT_OK;
    while (1) begin
      if (tab_x[left] == q) begin
        res.value = tab_y[left];
        return res;
      end
      if (tab_x[right] == q) begin
        res.value = tab_y[right];
        return res;
      end
      if (right <= left + 1) break;
      mid = left + (right - left) / 2;
      if (tab_x[mid] <= q) left = mid;
      else right = mid;
    end
    res.status = STAT_ORDER;
    if (right != left + 1) return res;
    if (left + k < n) start = left;
    else if (left + 1 >= k) start = left + 1 - k;
    else return res;
    for (int j = 0; j <= k; j++) begin
      xs[j] = tab_x[start + j];
      c[j] = tab_y[start + j];
    end
    for (int lvl = 1; lvl <= k; lvl++)
      for (int j = k; j >= lvl; j--)
        c[j] = sat_dd(quotient_q(c[j] - c[j-1], xs[j] - xs[j-lvl]));
    acc = c[k];
    for (int i = k - 1; i >= 0; i--)
      acc = sat_dd(c[i] + product_q(acc, longint'(q) - xs[i]));
    if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
    if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
    res.status = STAT_OK;
    res.value = acc[VAL_W-1:0];
    return res;
  endfunction

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 0;
    end else begin
      if (hold_req) begin
        hold_left = 700;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      interp_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: value %0d status %0d",
               out_result_value, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (out_status < 3) status_seen[out_status]++;
        if (out_result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, out_result_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic transfer_item(bit cmd, logic [IDX_W-1:0] slot, logic signed [VAL_W-1:0] px,
                               logic signed [VAL_W-1:0] py, logic signed [VAL_W-1:0] qx,
                               bit typed, interp_result_t typed_res);
    interp_result_t res;
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_command = cmd;
    in_point_index = slot;
    in_point_x = px;
    in_point_value = py;
    in_query_x = qx;
    in_valid = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      tab_x[slot] = px;
      tab_y[slot] = py;
      res.value = 0;
      res.status = STAT_OK;
    end else begin
      res = newton_at(qx);
    end
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_ORDER) cur_order = data[ORDER_W-1:0];
    else cur_points = data;
  endtask

  // sorted table over all slots; abscissa spacing varies per call
  task automatic load_sorted_table();
    interp_result_t none;
    longint step_max, xv;
    logic signed [VAL_W-1:0] yv;
    none = '{0, STAT_OK};
    case ($urandom_range(3))
      0: step_max = 16;
      1: step_max = Q1;
      2: step_max = 20'hF_FFFF;
      default: step_max = 24'hFF_FFFF;
    endcase
    xv = -(step_max * 128) + $urandom_range(15);
    for (int i = 0; i < 256; i++) begin
      if ($urandom_range(7) == 0) yv = $urandom;
      else yv = $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
      transfer_item(CMD_LOAD, IDX_W'(i), xv[VAL_W-1:0], yv, $urandom, 0, none);
      if ($urandom_range(19) != 0) xv += $urandom_range(1, step_max);
    end
  endtask

  task automatic random_item();
    interp_result_t none;
    int n, r;
    longint lo, hi, span, qv;
    logic [63:0] rnd;
    none = '{0, STAT_OK};
    n = (cur_points > 256) ? 256 : cur_points;
    r = $urandom_range(99);
    if (r >= 93) begin
      transfer_item(CMD_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom, 0, none);
    end else if (r >= 85 || n == 0) begin
      transfer_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom, 0, none);
    end else if (r >= 70) begin
      transfer_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom,
                    tab_x[$urandom_range(n - 1)], 0, none);
    end else begin
      lo = tab_x[0];
      hi = tab_x[n - 1];
      if (hi < lo) hi = lo;
      span = hi - lo + 1;
      rnd = {$urandom, $urandom};
      qv = lo + longint'(rnd % span);
      transfer_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom, qv[VAL_W-1:0], 0, none);
    end
  endtask

  stim_row_t directed_rows [] = '{
    '{ROW_LOAD,  0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, STAT_OK},
    '{ROW_LOAD,  1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, STAT_OK},
    '{ROW_QUERY, 0, 32'sh8000_0000, 0, 1, 32'sh7FFF_FFFF, STAT_OK},
    '{ROW_QUERY, 0, 32'sh7FFF_FFFF, 0, 1, 32'sh8000_0000, STAT_OK},
    '{ROW_QUERY, 0, 0, 0, 0, 0, STAT_OK},
    '{ROW_LOAD,  0, 0, 0, 1, 0, STAT_OK},
    '{ROW_LOAD,  1, Q1, Q1, 1, 0, STAT_OK},
    '{ROW_LOAD,  2, 2*Q1, 8*Q1, 1, 0, STAT_OK},
    '{ROW_LOAD,  3, 3*Q1, 27*Q1, 1, 0, STAT_OK},
    '{ROW_POINTS, 0, 0, 4, 0, 0, STAT_OK},
    '{ROW_ORDER, 0, 0, 3, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, Q1/2, 0, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, 3*Q1/2, 0, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, -1, 0, 1, 0, STAT_RANGE},
    '{ROW_QUERY, 0, 4*Q1, 0, 1, 0, STAT_RANGE},
    '{ROW_POINTS, 0, 0, 3, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, Q1/2, 0, 1, 0, STAT_ORDER},
    '{ROW_POINTS, 0, 0, 0, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, 0, 0, 1, 0, STAT_ORDER},
    '{ROW_POINTS, 0, 0, 4, 0, 0, STAT_OK},
    '{ROW_ORDER, 0, 0, 0, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, 5*Q1/2, 0, 0, 0, STAT_OK},
    '{ROW_ORDER, 0, 0, 2, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, 5*Q1/2, 0, 0, 0, STAT_OK},
    '{ROW_LOAD,  2, Q1, 5*Q1, 1, 0, STAT_OK},
    '{ROW_QUERY, 0, Q1/2, 0, 0, 0, STAT_OK},
    '{ROW_QUERY, 0, 3*Q1, 0, 1, 27*Q1, STAT_OK}
  };

  initial begin
    int n_sel;
    logic [CFG_DATA_W-1:0] pts_choice [8] = '{256, 511, 1, 2, 3, 4, 0, 17};
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_LOAD;
    in_point_index = 0;
    in_point_x = 0;
    in_point_value = 0;
    in_query_x = 0;
    cfg_we = 0;
    cfg_index = REG_ORDER;
    cfg_wdata = 0;
    cur_order = 1;
    cur_points = 2;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_ORDER:  write_reg(REG_ORDER, CFG_DATA_W'(directed_rows[i].y));
        ROW_POINTS: write_reg(REG_POINTS, CFG_DATA_W'(directed_rows[i].y));
        default: transfer_item(directed_rows[i].kind == ROW_QUERY ? CMD_QUERY : CMD_LOAD,
                               IDX_W'(directed_rows[i].slot), directed_rows[i].x,
                               directed_rows[i].y, directed_rows[i].x, directed_rows[i].typed,
                               '{directed_rows[i].exp_value, directed_rows[i].exp_status});
      endcase
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0 || ph == 6) begin
        gap_pct = 0;
        stall_pct = 0;
        load_sorted_table();
      end
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 51; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 51; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      write_reg(REG_ORDER, CFG_DATA_W'((ph < 4) ? 3 - ph : $urandom_range(3)));
      n_sel = ph % 8;
      write_reg(REG_POINTS, (n_sel == 7) ? CFG_DATA_W'($urandom_range(5, 255))
                                         : pts_choice[n_sel]);
      // fill the block while the receiver holds off
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < 28; i++) random_item();
      // pause the sender until every result is back
      if (ph == 8) drain_results();
    end

    drain_results();
    repeat (50) @(negedge clk);
    $display("checked %0d results: %0d ok, %0d out of range, %0d order errors",
             n_results, status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0)
      $display("[table_newton_interpolator] OK");
    else
      $display("[table_newton_interpolator] ERROR");
    $finish;
  end

endmodule
